// ----- rtl/core/bltok_pkg.sv -----
// package: types, constants and helper functions of the brace language tokenizer
`timescale 1ns / 1ps
`default_nettype none

package bltok_pkg;

    localparam int OFFSET_BITS    = 32;
    localparam int LINE_BITS      = 24;
    localparam int COLUMN_BITS    = 16;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LINE_BITS-1:0]   LINE_RESET   = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COLUMN_RESET = '0;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_LINE   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_COLUMN = CFG_INDEX_BITS'(1);

    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_SLASH  = 8'h2F;
    localparam logic [7:0] CHR_COLON  = 8'h3A;
    localparam logic [7:0] CHR_SEMI   = 8'h3B;
    localparam logic [7:0] CHR_EQUALS = 8'h3D;
    localparam logic [7:0] CHR_LBRACE = 8'h7B;
    localparam logic [7:0] CHR_RBRACE = 8'h7D;

    typedef enum logic [3:0] {
        KIND_LBRACE  = 4'd0,
        KIND_RBRACE  = 4'd1,
        KIND_SEMI    = 4'd2,
        KIND_COLON   = 4'd3,
        KIND_EQUALS  = 4'd4,
        KIND_STRING  = 4'd5,
        KIND_IDENT   = 4'd6,
        KIND_TEXT    = 4'd7,
        KIND_STYLE   = 4'd8,
        KIND_SCRIPT  = 4'd9,
        KIND_EOF     = 4'd10,
        KIND_UNTERM  = 4'd11
    } token_kind_t;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_SLASH   = 5'b00010,
        MODE_COMMENT = 5'b00100,
        MODE_STRING  = 5'b01000,
        MODE_IDENT   = 5'b10000
    } lex_mode_t;

    typedef struct packed {
        token_kind_t             kind;
        logic [OFFSET_BITS-1:0]  start;
        logic [OFFSET_BITS-1:0]  length;
        logic [LINE_BITS-1:0]    line;
        logic [COLUMN_BITS-1:0]  column;
        logic                    last;
    } tok_rec_t;

    typedef struct packed {
        logic     valid0;
        logic     valid1;
        tok_rec_t rec0;
        tok_rec_t rec1;
    } push_t;

    typedef struct packed {
        logic stream_done;
        logic started;
    } front_stat_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_letter(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    // keyword letters: text, style, script
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            2'd0:
            begin
                case (idx)
                    3'd0: ch = 8'h74;
                    3'd1: ch = 8'h65;
                    3'd2: ch = 8'h78;
                    3'd3: ch = 8'h74;
                    default: ch = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (idx)
                    3'd0: ch = 8'h73;
                    3'd1: ch = 8'h74;
                    3'd2: ch = 8'h79;
                    3'd3: ch = 8'h6C;
                    3'd4: ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            end
            2'd2:
            begin
                case (idx)
                    3'd0: ch = 8'h73;
                    3'd1: ch = 8'h63;
                    3'd2: ch = 8'h72;
                    3'd3: ch = 8'h69;
                    3'd4: ch = 8'h70;
                    3'd5: ch = 8'h74;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] n;
        case (k)
            2'd0: n = 3'd4;
            2'd1: n = 3'd5;
            2'd2: n = 3'd6;
            default: n = 3'd7;
        endcase
        return n;
    endfunction

    // drop candidates whose letter at idx differs from c
    function automatic logic [2:0] kw_match(input logic [2:0] cand, input logic [2:0] idx,
                                            input logic [7:0] c);
        logic [2:0] r;
        r = cand;
        for (int k = 0; k < 3; k++)
        begin
            if (idx >= kw_len(2'(k)) || kw_char(2'(k), idx) != c)
                r[k] = 1'b0;
        end
        return r;
    endfunction

    function automatic token_kind_t ident_kind(input logic [2:0] cand, input logic [2:0] len);
        token_kind_t kd;
        kd = KIND_IDENT;
        if (cand[0] && len == kw_len(2'd0)) kd = KIND_TEXT;
        if (cand[1] && len == kw_len(2'd1)) kd = KIND_STYLE;
        if (cand[2] && len == kw_len(2'd2)) kd = KIND_SCRIPT;
        return kd;
    endfunction

    function automatic logic [LINE_BITS-1:0] line_sat_inc(input logic [LINE_BITS-1:0] v);
        return (v == '1) ? v : v + LINE_BITS'(1);
    endfunction

    function automatic logic [COLUMN_BITS-1:0] col_sat_inc(input logic [COLUMN_BITS-1:0] v);
        return (v == '1) ? v : v + COLUMN_BITS'(1);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bltok_if.sv -----
// interfaces: source byte channel, token channel and configuration write channel
`timescale 1ns / 1ps
`default_nettype none

interface bltok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_input;

    modport source (output valid, output source_byte, output end_of_input, input ready);
    modport sink (input valid, input source_byte, input end_of_input, output ready);
endinterface

interface bltok_out_if;
    import bltok_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [3:0]             token_kind;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [OFFSET_BITS-1:0] token_length;
    logic [LINE_BITS-1:0]   line_number;
    logic [COLUMN_BITS-1:0] column_number;
    logic                   last_of_run;

    modport source (output valid, output token_kind, output start_offset, output token_length,
                    output line_number, output column_number, output last_of_run,
                    input ready);
    modport sink (input valid, input token_kind, input start_offset, input token_length,
                  input line_number, input column_number, input last_of_run,
                  output ready);
endinterface

interface bltok_cfg_if;
    import bltok_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/brace_language_tokenizer_top.sv -----
// top level of the brace language tokenizer
//
//  channel   dir   payload                                            handshake
//  byte_ch   in    source_byte, end_of_input                          valid/ready
//  token_ch  out   token_kind, start_offset, token_length,            valid/ready
//                  line_number, column_number, last_of_run
//  cfg_ch    in    index, data (0 first_line, 1 first_column)         valid/ready
//
//  one source byte beat per cycle while byte_ch.ready is high; the front end
//  decides its tokens in the same cycle and writes up to two records into a
//  four-entry queue; token beats leave the registered queue, one token per cycle
//  while token_ch.ready is high, so two-token byte runs are held to that rate
//  byte_ch.ready is low only while the queue holds more than two records
//  reset clears all lexing state; no clearing pass, ready right after reset
//  cfg_ch is always ready; a start position loads only before the first beat
`timescale 1ns / 1ps
`default_nettype none

module brace_language_tokenizer_top
    import bltok_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bltok_in_if.sink    byte_ch,
    bltok_out_if.source token_ch,
    bltok_cfg_if.sink   cfg_ch
);

    push_t       push;
    front_stat_t stat;
    logic        room;
    logic        head_valid;
    tok_rec_t    head;

    // front end: classifies each byte and builds tokens
    bltok_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .cfg_ch  (cfg_ch),
        .room    (room),
        .push    (push),
        .stat    (stat)
    );

    // back end: queue of finished tokens, head drives the token channel
    bltok_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (head_valid),
        .head       (head),
        .pop_ready  (token_ch.ready)
    );

    assign token_ch.valid         = head_valid;
    assign token_ch.token_kind    = head.kind;
    assign token_ch.start_offset  = head.start;
    assign token_ch.token_length  = head.length;
    assign token_ch.line_number   = head.line;
    assign token_ch.column_number = head.column;
    assign token_ch.last_of_run   = head.last;

    // end of stream stays set
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stat.stream_done |=> stat.stream_done)
        else $error("stream done flag dropped");

    // an accepted end marker always leaves an eof token to deliver
    a_eof_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_ch.valid && byte_ch.ready && byte_ch.end_of_input && !stat.stream_done)
        |=> token_ch.valid)
        else $error("end marker accepted but no token queued");

    // the second record of a beat is only ever written with the first
    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid1 |-> push.valid0 && !push.rec0.last && push.rec1.last)
        else $error("token pair written out of order");

    // any accepted beat marks the stream as started
    a_started: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_ch.valid && byte_ch.ready) |=> stat.started)
        else $error("accepted beat did not mark the stream started");

endmodule

`default_nettype wire

// ----- rtl/core/bltok_front.sv -----
// front end: lexing state, position counters and token building
`timescale 1ns / 1ps
`default_nettype none

module bltok_front
    import bltok_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bltok_in_if.sink   byte_ch,
    bltok_cfg_if.sink  cfg_ch,
    input  wire logic  room,
    output push_t      push,
    output front_stat_t stat
);

    lex_mode_t              mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [2:0]             cand_reg, cand_next;
    logic [2:0]             idlen_reg, idlen_next;
    logic                   done_reg, done_next;
    logic                   started_reg, started_next;

    logic [7:0]  c;
    logic        eoi;
    logic        accept;
    logic        cfg_accept;
    logic        is_lf;
    logic        idle_path;
    logic        a_valid, b_valid;
    tok_rec_t    tok_a, tok_b;
    logic        sc_valid;
    token_kind_t sc_kind;

    logic [OFFSET_BITS-1:0] offset_adv;
    logic [LINE_BITS-1:0]   line_adv;
    logic [COLUMN_BITS-1:0] col_adv;
    logic [OFFSET_BITS-1:0] str_start;
    logic [OFFSET_BITS-1:0] str_len;

    assign c          = byte_ch.source_byte;
    assign eoi        = byte_ch.end_of_input;
    assign byte_ch.ready = room;
    assign accept     = byte_ch.valid && room;
    assign cfg_ch.ready  = 1'b1;
    assign cfg_accept = cfg_ch.valid;
    assign is_lf      = (c == CHR_LF);

    assign offset_adv = offset_reg + OFFSET_BITS'(1);
    assign line_adv   = is_lf ? line_sat_inc(line_reg) : line_reg;
    assign col_adv    = is_lf ? COLUMN_BITS'(1) : col_sat_inc(col_reg);
    assign str_start  = start_reg + OFFSET_BITS'(1);
    assign str_len    = offset_reg - start_reg - OFFSET_BITS'(1);

    // one-byte tokens
    always_comb
    begin
        sc_valid = 1'b1;
        sc_kind  = KIND_LBRACE;
        case (c)
            CHR_LBRACE: sc_kind = KIND_LBRACE;
            CHR_RBRACE: sc_kind = KIND_RBRACE;
            CHR_SEMI:   sc_kind = KIND_SEMI;
            CHR_COLON:  sc_kind = KIND_COLON;
            CHR_EQUALS: sc_kind = KIND_EQUALS;
            default:    sc_valid = 1'b0;
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            MODE_SLASH:   idle_path = (c != CHR_SLASH);
            MODE_COMMENT: idle_path = 1'b0;
            MODE_STRING:  idle_path = 1'b0;
            MODE_IDENT:   idle_path = !is_alnum(c);
            default:      idle_path = 1'b1;
        endcase
    end

    // token a: pending identifier or open string closed by this beat
    always_comb
    begin
        a_valid      = 1'b0;
        tok_a.kind   = ident_kind(cand_reg, idlen_reg);
        tok_a.start  = start_reg;
        tok_a.length = offset_reg - start_reg;
        tok_a.line   = line_reg;
        tok_a.column = col_reg;
        if (mode_reg == MODE_IDENT && (eoi || !is_alnum(c)))
            a_valid = 1'b1;
        if (mode_reg == MODE_STRING && eoi)
        begin
            a_valid      = 1'b1;
            tok_a.kind   = KIND_UNTERM;
            tok_a.start  = str_start;
            tok_a.length = str_len;
        end
        tok_a.last = !b_valid;
    end

    // token b: eof, one-byte token or closed string
    always_comb
    begin
        b_valid      = 1'b0;
        tok_b.kind   = sc_kind;
        tok_b.start  = offset_reg;
        tok_b.length = OFFSET_BITS'(1);
        tok_b.line   = line_adv;
        tok_b.column = col_adv;
        tok_b.last   = 1'b1;
        if (eoi)
        begin
            b_valid      = 1'b1;
            tok_b.kind   = KIND_EOF;
            tok_b.length = '0;
            tok_b.line   = line_reg;
            tok_b.column = col_reg;
        end
        else if (idle_path && sc_valid)
            b_valid = 1'b1;
        else if (mode_reg == MODE_STRING && c == CHR_QUOTE)
        begin
            b_valid      = 1'b1;
            tok_b.kind   = KIND_STRING;
            tok_b.start  = str_start;
            tok_b.length = str_len;
        end
    end

    always_comb
    begin
        push.valid0 = accept && !done_reg && (a_valid || b_valid);
        push.valid1 = accept && !done_reg && a_valid && b_valid;
        push.rec0   = a_valid ? tok_a : tok_b;
        push.rec1   = tok_b;
    end

    always_comb
    begin
        mode_next    = mode_reg;
        offset_next  = offset_reg;
        start_next   = start_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        cand_next    = cand_reg;
        idlen_next   = idlen_reg;
        done_next    = done_reg;
        started_next = started_reg;
        if (accept && !done_reg)
        begin
            started_next = 1'b1;
            if (eoi)
            begin
                mode_next = MODE_IDLE;
                done_next = 1'b1;
            end
            else
            begin
                offset_next = offset_adv;
                line_next   = line_adv;
                col_next    = col_adv;
                if (idle_path)
                begin
                    mode_next = MODE_IDLE;
                    if (c == CHR_SLASH)
                    begin
                        mode_next  = MODE_SLASH;
                        start_next = offset_reg;
                    end
                    else if (c == CHR_QUOTE)
                    begin
                        mode_next  = MODE_STRING;
                        start_next = offset_reg;
                    end
                    else if (is_letter(c))
                    begin
                        mode_next  = MODE_IDENT;
                        start_next = offset_reg;
                        cand_next  = kw_match(3'b111, 3'd0, c);
                        idlen_next = 3'd1;
                    end
                end
                else
                begin
                    case (mode_reg)
                        MODE_SLASH:   mode_next = MODE_COMMENT;
                        MODE_COMMENT: mode_next = is_lf ? MODE_IDLE : MODE_COMMENT;
                        MODE_STRING:  mode_next = (c == CHR_QUOTE) ? MODE_IDLE : MODE_STRING;
                        MODE_IDENT:
                        begin
                            cand_next  = kw_match(cand_reg, idlen_reg, c);
                            idlen_next = (idlen_reg == 3'd7) ? idlen_reg : idlen_reg + 3'd1;
                        end
                        default:      mode_next = MODE_IDLE;
                    endcase
                end
            end
        end
        else if (cfg_accept && !started_reg)
        begin
            // start position loads only before the first beat
            case (cfg_ch.index)
                REG_FIRST_LINE:   line_next = cfg_ch.data[LINE_BITS-1:0];
                REG_FIRST_COLUMN: col_next  = cfg_ch.data[COLUMN_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            offset_reg  <= '0;
            start_reg   <= '0;
            line_reg    <= LINE_RESET;
            col_reg     <= COLUMN_RESET;
            cand_reg    <= 3'b111;
            idlen_reg   <= 3'd0;
            done_reg    <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            offset_reg  <= offset_next;
            start_reg   <= start_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            cand_reg    <= cand_next;
            idlen_reg   <= idlen_next;
            done_reg    <= done_next;
            started_reg <= started_next;
        end
    end

    assign stat.stream_done = done_reg;
    assign stat.started     = started_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bltok_queue.sv -----
// token queue: up to two writes and one read per cycle, the read only while the sink is ready
`timescale 1ns / 1ps
`default_nettype none

module bltok_queue
    import bltok_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  push_t      push,
    output logic       room,
    output logic       head_valid,
    output tok_rec_t   head,
    input  wire logic  pop_ready
);

    tok_rec_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_reg, wr_next;
    logic [QPTR_BITS-1:0] rd_reg, rd_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic [QPTR_BITS-1:0] wr_plus1;
    logic                 pop;

    assign wr_plus1   = wr_reg + QPTR_BITS'(1);
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_reg];
    assign pop        = head_valid && pop_ready;
    // room for two records, the most one beat can bring
    assign room       = (count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_next    = wr_reg + QPTR_BITS'(push.valid0) + QPTR_BITS'(push.valid1);
        rd_next    = rd_reg + QPTR_BITS'(pop);
        count_next = count_reg + QCNT_BITS'(push.valid0) + QCNT_BITS'(push.valid1)
                     - QCNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid0)
            mem_reg[wr_reg] <= push.rec0;
        if (push.valid1)
            mem_reg[wr_plus1] <= push.rec1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- test/bltok_token_checker.sv -----
// checker: predicts the token beats of the tokenizer and compares them with what it sends
`timescale 1ns / 1ps

module bltok_token_checker
    import bltok_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bltok_in_if       byte_ch,
    bltok_out_if      token_ch,
    bltok_cfg_if      cfg_ch,
    output int        errors,
    output int        pending
);

    localparam logic [31:0] WORD_TEXT   = "text";
    localparam logic [39:0] WORD_STYLE  = "style";
    localparam logic [47:0] WORD_SCRIPT = "script";
    localparam int          REPORT_CAP  = 200;

    // own copy of the tokenizer state
    logic [LINE_BITS-1:0]   line_start;
    logic [COLUMN_BITS-1:0] column_start;
    lex_mode_t              mode;
    logic [OFFSET_BITS-1:0] offset;
    logic [OFFSET_BITS-1:0] tok_start;
    logic [LINE_BITS-1:0]   line_cnt;
    logic [COLUMN_BITS-1:0] col_cnt;
    logic [55:0]            word;
    logic [2:0]             word_len;
    logic                   done;
    logic                   taken_any;

    tok_rec_t tokens_due[$];
    int       tokens_seen;

    initial
    begin
        errors      = 0;
        pending     = 0;
        tokens_seen = 0;
    end

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (errors < REPORT_CAP)
            $display("%0t: token %0d %s: got 0x%0h, expected 0x%0h",
                     $time, tokens_seen, what, got, want);
        errors++;
    endtask

    task automatic clear_model();
        line_start   = LINE_RESET;
        column_start = COLUMN_RESET;
        mode         = MODE_IDLE;
        offset       = '0;
        tok_start    = '0;
        line_cnt     = LINE_RESET;
        col_cnt      = COLUMN_RESET;
        word         = '0;
        word_len     = '0;
        done         = 1'b0;
        taken_any    = 1'b0;
        tokens_due.delete();
    endtask

    task automatic advance();
        offset = offset + OFFSET_BITS'(1);
        if (col_cnt != '1)
            col_cnt = col_cnt + COLUMN_BITS'(1);
    endtask

    task automatic new_line();
        if (line_cnt != '1)
            line_cnt = line_cnt + LINE_BITS'(1);
        col_cnt = '0;
        advance();
    endtask

    task automatic push_token(input token_kind_t kind, input logic [OFFSET_BITS-1:0] start,
                              input logic [OFFSET_BITS-1:0] len);
        tok_rec_t t;
        t.kind   = kind;
        t.start  = start;
        t.length = len;
        t.line   = line_cnt;
        t.column = col_cnt;
        t.last   = 1'b0;
        tokens_due.insert(tokens_due.size(), t);
    endtask

    // keywords only match on their exact length
    task automatic close_word();
        token_kind_t kind;
        kind = KIND_IDENT;
        if (word_len == 3'd4 && word[31:0] == WORD_TEXT)
            kind = KIND_TEXT;
        else if (word_len == 3'd5 && word[39:0] == WORD_STYLE)
            kind = KIND_STYLE;
        else if (word_len == 3'd6 && word[47:0] == WORD_SCRIPT)
            kind = KIND_SCRIPT;
        push_token(kind, tok_start, offset - tok_start);
    endtask

    task automatic add_word_char(input logic [7:0] c);
        if (word_len != 3'd7)
        begin
            word     = {word[47:0], c};
            word_len = word_len + 3'd1;
        end
    endtask

    task automatic from_idle(input logic [7:0] c);
        token_kind_t kind;
        kind = KIND_LBRACE;
        if (c == CHR_SPACE || c == CHR_TAB || c == CHR_CR)
            advance();
        else if (c == CHR_LF)
            new_line();
        else if (c == CHR_SLASH || c == CHR_QUOTE)
        begin
            tok_start = offset;
            advance();
            mode = (c == CHR_SLASH) ? MODE_SLASH : MODE_STRING;
        end
        else if (c == CHR_LBRACE || c == CHR_RBRACE || c == CHR_SEMI || c == CHR_COLON
                 || c == CHR_EQUALS)
        begin
            if (c == CHR_RBRACE)
                kind = KIND_RBRACE;
            else if (c == CHR_SEMI)
                kind = KIND_SEMI;
            else if (c == CHR_COLON)
                kind = KIND_COLON;
            else if (c == CHR_EQUALS)
                kind = KIND_EQUALS;
            tok_start = offset;
            advance();
            push_token(kind, tok_start, OFFSET_BITS'(1));
        end
        else if (is_alpha(c))
        begin
            tok_start = offset;
            advance();
            word     = '0;
            word_len = '0;
            add_word_char(c);
            mode = MODE_IDENT;
        end
        else
            advance();
    endtask

    task automatic lex_byte(input logic [7:0] c);
        logic [OFFSET_BITS-1:0] len;
        case (mode)
            MODE_SLASH:
            begin
                if (c == CHR_SLASH)
                begin
                    advance();
                    mode = MODE_COMMENT;
                end
                else
                begin
                    mode = MODE_IDLE;
                    from_idle(c);
                end
            end
            MODE_COMMENT:
            begin
                if (c == CHR_LF)
                begin
                    mode = MODE_IDLE;
                    new_line();
                end
                else
                    advance();
            end
            MODE_STRING:
            begin
                if (c == CHR_QUOTE)
                begin
                    len = offset - tok_start - OFFSET_BITS'(1);
                    advance();
                    push_token(KIND_STRING, tok_start + OFFSET_BITS'(1), len);
                    mode = MODE_IDLE;
                end
                else if (c == CHR_LF)
                    new_line();
                else
                    advance();
            end
            MODE_IDENT:
            begin
                if (is_alpha(c) || (c >= "0" && c <= "9"))
                begin
                    advance();
                    add_word_char(c);
                end
                else
                begin
                    close_word();
                    mode = MODE_IDLE;
                    from_idle(c);
                end
            end
            default:
            begin
                mode = MODE_IDLE;
                from_idle(c);
            end
        endcase
    endtask

    task automatic take_beat(input logic [7:0] c, input logic eoi);
        int before_n;
        before_n = tokens_due.size();
        if (!done)
        begin
            taken_any = 1'b1;
            if (eoi)
            begin
                if (mode == MODE_IDENT)
                    close_word();
                else if (mode == MODE_STRING)
                    push_token(KIND_UNTERM, tok_start + OFFSET_BITS'(1),
                               offset - tok_start - OFFSET_BITS'(1));
                mode = MODE_IDLE;
                push_token(KIND_EOF, offset, '0);
                done = 1'b1;
            end
            else
                lex_byte(c);
            if (tokens_due.size() > before_n)
                tokens_due[tokens_due.size() - 1].last = 1'b1;
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        if (idx == REG_FIRST_LINE)
        begin
            line_start = value[LINE_BITS-1:0];
            if (!taken_any)
                line_cnt = line_start;
        end
        else if (idx == REG_FIRST_COLUMN)
        begin
            column_start = value[COLUMN_BITS-1:0];
            if (!taken_any)
                col_cnt = column_start;
        end
    endtask

    task automatic check_token();
        tok_rec_t want;
        tokens_seen++;
        if (tokens_due.size() == 0)
            report("arrived with none due, kind", 64'(token_ch.token_kind), '0);
        else
        begin
            want = tokens_due.pop_front();
            if (token_ch.token_kind != want.kind)
                report("token_kind", 64'(token_ch.token_kind), 64'(want.kind));
            if (token_ch.start_offset != want.start)
                report("start_offset", 64'(token_ch.start_offset), 64'(want.start));
            if (token_ch.token_length != want.length)
                report("token_length", 64'(token_ch.token_length), 64'(want.length));
            if (token_ch.line_number != want.line)
                report("line_number", 64'(token_ch.line_number), 64'(want.line));
            if (token_ch.column_number != want.column)
                report("column_number", 64'(token_ch.column_number), 64'(want.column));
            if (token_ch.last_of_run != want.last)
                report("last_of_run", 64'(token_ch.last_of_run), 64'(want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_model();
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                write_reg(cfg_ch.index, cfg_ch.data);
            if (byte_ch.valid && byte_ch.ready)
                take_beat(byte_ch.source_byte, byte_ch.end_of_input);
            if (token_ch.valid && token_ch.ready)
                check_token();
        end
        pending = tokens_due.size();
    end

endmodule

// ----- test/tb_top.sv -----
// testbench top: clock, reset, byte and configuration stimulus, token back-pressure, verdict
`timescale 1ns / 1ps

module tb_top;
    import bltok_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int PHASES        = 3;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 4;   // front end decides in the beat cycle, token leaves the registered queue
    localparam int TAIL_CYCLES   = 20;
    localparam int MAX_GAP       = 9;

    // an index that names no register: the write must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = '1;

    // ways to leave the stream open when the end marker comes
    typedef enum int {
        TAIL_WORD,
        TAIL_STRING,
        TAIL_COMMENT,
        TAIL_SLASH,
        TAIL_BLANK
    } tail_t;

    logic        clk;
    logic        rst_n;
    logic        no_idle;       // high for stretches where neither side idles
    int          bytes_sent;
    int          error_count;
    int          pending_count;
    int unsigned cycle_count = 0;

    bltok_in_if  byte_ch();
    bltok_out_if token_ch();
    bltok_cfg_if cfg_ch();

    brace_language_tokenizer_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .token_ch (token_ch),
        .cfg_ch   (cfg_ch)
    );

    bltok_token_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .token_ch (token_ch),
        .cfg_ch   (cfg_ch),
        .errors   (error_count),
        .pending  (pending_count)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // hard stop in case the block hangs or tokens go missing
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // idle cycles before the next beat, on either side
    function automatic int draw_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [7:0] alpha_pick();
        int r;
        r = $urandom_range(0, 51);
        if (r < 26)
            return 8'("A" + r);
        return 8'("a" + r - 26);
    endfunction

    function automatic logic [7:0] word_char_pick();
        if ($urandom_range(0, 3) == 0)
            return 8'("0" + $urandom_range(0, 9));
        return alpha_pick();
    endfunction

    // token side: after each beat, ready drops for a drawn number of cycles
    initial
    begin
        int wait_left;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            if (token_ch.valid && token_ch.ready)
                wait_left = draw_gap();
            @(negedge clk);
            if (wait_left > 0)
            begin
                token_ch.ready <= 1'b0;
                wait_left--;
            end
            else
                token_ch.ready <= 1'b1;
        end
    end

    // one byte beat; entered and left at a falling edge, valid is left high so that a
    // back-to-back beat needs no second assignment in the same step
    task automatic send_item(input logic [7:0] b, input logic eoi);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.source_byte  <= b;
        byte_ch.end_of_input <= eoi;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // stop sending and hold off until every predicted token has come out
    task automatic wait_for_tokens();
        byte_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one lexical fragment with random content; mostly well formed, some noise
    task automatic send_fragment();
        logic [7:0] bytes[$];
        logic [7:0] c;
        string      kw;
        int         pick;
        int         n;
        int         p;
        pick = $urandom_range(0, 99);
        n    = $urandom_range(0, 2);
        if (n == 0)
            kw = "text";
        else if (n == 1)
            kw = "style";
        else
            kw = "script";

        if (pick < 20)
        begin
            // single-byte tokens
            n = $urandom_range(0, 4);
            if (n == 0)
                bytes.insert(bytes.size(), CHR_LBRACE);
            else if (n == 1)
                bytes.insert(bytes.size(), CHR_RBRACE);
            else if (n == 2)
                bytes.insert(bytes.size(), CHR_SEMI);
            else if (n == 3)
                bytes.insert(bytes.size(), CHR_COLON);
            else
                bytes.insert(bytes.size(), CHR_EQUALS);
        end
        else if (pick < 33)
        begin
            n = $urandom_range(0, 2);
            if (n == 0)
                bytes.insert(bytes.size(), CHR_SPACE);
            else if (n == 1)
                bytes.insert(bytes.size(), CHR_TAB);
            else
                bytes.insert(bytes.size(), CHR_CR);
        end
        else if (pick < 41)
            bytes.insert(bytes.size(), CHR_LF);
        else if (pick < 53)
        begin
            for (int i = 0; i < kw.len(); i++)
                bytes.insert(bytes.size(), kw[i]);
        end
        else if (pick < 61)
        begin
            // near misses: cut short, run on, wrong case, wrong letter
            for (int i = 0; i < kw.len(); i++)
                bytes.insert(bytes.size(), kw[i]);
            n = $urandom_range(0, 3);
            p = $urandom_range(0, kw.len() - 1);
            if (n == 0)
                void'(bytes.pop_back());
            else if (n == 1)
                bytes.insert(bytes.size(), word_char_pick());
            else if (n == 2)
                bytes[p] = bytes[p] ^ 8'h20;
            else
                bytes[p] = alpha_pick();
        end
        else if (pick < 73)
        begin
            bytes.insert(bytes.size(), alpha_pick());
            n = $urandom_range(0, 8);
            repeat (n) bytes.insert(bytes.size(), word_char_pick());
        end
        else if (pick < 83)
        begin
            // string with any content but a quote, line feeds now and then
            bytes.insert(bytes.size(), CHR_QUOTE);
            n = $urandom_range(0, 8);
            repeat (n)
            begin
                c = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 9) == 0)
                    c = CHR_LF;
                else if (c == CHR_QUOTE)
                    c = "x";
                bytes.insert(bytes.size(), c);
            end
            bytes.insert(bytes.size(), CHR_QUOTE);
        end
        else if (pick < 88)
        begin
            bytes.insert(bytes.size(), CHR_SLASH);
            bytes.insert(bytes.size(), CHR_SLASH);
            n = $urandom_range(0, 10);
            repeat (n)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == CHR_LF)
                    c = CHR_SLASH;
                bytes.insert(bytes.size(), c);
            end
            bytes.insert(bytes.size(), CHR_LF);
        end
        else if (pick < 92)
            bytes.insert(bytes.size(), CHR_SLASH);
        else
            bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));

        // now and then switch between idling and full-rate stretches
        if ($urandom_range(0, 19) == 0)
            no_idle = !no_idle;

        foreach (bytes[i])
            send_item(bytes[i], 1'b0);
    endtask

    initial
    begin
        logic [7:0] opening [25];
        int         target;
        tail_t      tail;

        // every input known from the start
        no_idle              = 1'b0;
        bytes_sent           = 0;
        rst_n                = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.source_byte  = '0;
        byte_ch.end_of_input = 1'b0;
        token_ch.ready       = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // before the first byte every position write also sets the start position; the
        // last two leave the column just short of saturation and the line 15 to 40
        // line feeds short of it, with junk in the unused upper data bits
        cfg_write(REG_FIRST_LINE, '0);
        cfg_write(REG_FIRST_COLUMN, '1);
        cfg_write(REG_FIRST_LINE, '1);
        cfg_write(REG_UNUSED, $urandom());
        cfg_write(REG_FIRST_LINE, {8'($urandom_range(0, 255)),
                                   24'hFFFFFF - 24'($urandom_range(15, 40))});
        cfg_write(REG_FIRST_COLUMN, {16'($urandom_range(0, 65535)), 16'hFFFC});

        // directed opening: all single-byte tokens, extreme bytes, lone slash before a
        // letter, identifier ended by a slash, comment, string across a line feed,
        // empty string, keyword followed by a token in the same beat
        opening = '{CHR_LBRACE, CHR_RBRACE, CHR_SEMI, CHR_COLON, CHR_EQUALS,
                    8'hFF, 8'h00, CHR_SLASH, "x", "9", CHR_SLASH, CHR_SLASH, "q",
                    CHR_LF, CHR_QUOTE, CHR_LF, CHR_QUOTE, CHR_QUOTE, CHR_QUOTE,
                    "t", "e", "x", "t", CHR_EQUALS, CHR_SPACE};
        foreach (opening[i])
            send_item(opening[i], 1'b0);

        // random phases; between them the sender drains the block and rewrites the
        // registers, which must no longer move the position once bytes have gone in
        for (int ph = 0; ph < PHASES; ph++)
        begin
            target = bytes_sent + RANDOM_ITEMS / PHASES;
            while (bytes_sent < target)
                send_fragment();
            if (ph < PHASES - 1)
            begin
                wait_for_tokens();
                if (ph == 0)
                begin
                    cfg_write(REG_FIRST_LINE, '0);
                    cfg_write(REG_FIRST_COLUMN, 32'h0000FFFF);
                end
                else
                begin
                    cfg_write(REG_FIRST_LINE, '1);
                    cfg_write(REG_FIRST_COLUMN, '0);
                    cfg_write(REG_UNUSED, '0);
                end
            end
        end

        // leave something open for the end marker to flush
        tail = tail_t'($urandom_range(0, 4));
        if (tail == TAIL_WORD)
            send_text("ab9");
        else if (tail == TAIL_STRING)
        begin
            send_item(CHR_QUOTE, 1'b0);
            send_text("q");
        end
        else if (tail == TAIL_COMMENT)
            send_text("//x");
        else if (tail == TAIL_SLASH)
            send_item(CHR_SLASH, 1'b0);
        else
            send_item(CHR_SPACE, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);

        // after the end everything is ignored, a second end marker too
        send_item(8'($urandom_range(0, 255)), 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        send_text("a{");
        byte_ch.valid <= 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
